@@ hdl/trajectory_stay_region_extractor_macros.svh @@
// Assertion macros shared by the stay-region extractor.
`ifndef TRAJECTORY_STAY_REGION_EXTRACTOR_MACROS_SVH
`define TRAJECTORY_STAY_REGION_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define TSRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define TSRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tsre_pkg.sv @@
// Package with the types and constants shared by the stay-region extractor.
`default_nettype none

package tsre_pkg;

    localparam int COORD_W     = 32;
    localparam int EXTENT_W    = 31;
    localparam int MINPTS_W    = 7;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 256;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXTENT_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_POINTS   = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK
    } t_state;

    typedef struct packed {
        logic load_in;
        logic emit;
        logic flush;
        logic new_user;
        logic grow;
        logic reseed;
        logic walk_start;
        logic absorb;
        logic walk_end;
        logic walk_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_flush;
        logic new_user;
        logic fits;
        logic big;
        logic walk_done;
    } t_dp_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_min_x;
        logic [31:0]               end_index;
        logic [31:0]               start_index;
        logic [31:0]               region_points;
        logic [31:0]               region_user;
    } t_region;

endpackage

`default_nettype wire

@@ hdl/trajectory_stay_region_extractor.sv @@
// Top level of the stay-region extractor: channels, configuration registers and result register.
//
// Channel       Direction  Payload
// s_axis        in         tdata: user_id, x_coord, y_coord; tuser: cmd
// m_axis        out        tdata: region_user .. box_max_y
// cfg           in         i_cfg_index, i_cfg_data
//
// A request is taken in S_IDLE and decided in S_DECIDE.
// A breaking point of a region that is too small walks the recent-point buffer backward,
// one buffered point per cycle through its single read port. Reset is synchronous; the
// recent-point buffer is not cleared.
// A result waits in the output register while the next request is taken; only a decision that
// must report while that register is still full waits for it to drain.
`default_nettype none

`include "trajectory_stay_region_extractor_macros.svh"

module trajectory_stay_region_extractor #(
    parameter int MAX_MIN_POINTS = 64
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // user_id [31:0], x_coord [63:32], y_coord [95:64]
    input  wire  [tsre_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd [0]
    input  wire  [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // region_user, region_points, start_index, end_index, box_min_x, box_max_x,
    // box_min_y, box_max_y, 32 bits each from the lowest bit up
    output logic [tsre_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [tsre_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire  [tsre_pkg::EXTENT_W-1:0]        i_cfg_data
);

    logic [tsre_pkg::EXTENT_W-1:0] r_extent_limit;
    logic [tsre_pkg::MINPTS_W-1:0] r_min_points;
    logic                          r_m_valid;
    tsre_pkg::t_region             r_m_data;

    tsre_pkg::t_dp_cmd             cmd;
    tsre_pkg::t_dp_status          status;
    tsre_pkg::t_region             region;
    logic                          out_free;

    assign o_cfg_ready   = i_rst_n;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extent_limit <= '0;
            r_min_points   <= tsre_pkg::MINPTS_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsre_pkg::CFG_EXTENT_LIMIT: r_extent_limit <= i_cfg_data;
                tsre_pkg::CFG_MIN_POINTS:   r_min_points   <= i_cfg_data[tsre_pkg::MINPTS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_m_data <= region;
        end
    end

    tsre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    tsre_datapath #(
        .MAX_MIN_POINTS (MAX_MIN_POINTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in_cmd       (s_axis_tuser[0]),
        .i_in_user      (s_axis_tdata[31:0]),
        .i_in_x         (s_axis_tdata[63:32]),
        .i_in_y         (s_axis_tdata[95:64]),
        .i_extent_limit (r_extent_limit),
        .i_min_points   (r_min_points),
        .o_status       (status),
        .o_region       (region)
    );

    `TSRE_ASSERT_NOW(a_emit_slot_free, cmd.emit, out_free, "result loaded over a pending result")
    `TSRE_ASSERT_NOW(a_emit_not_accepting, cmd.emit, !s_axis_tready, "result issued while idle")
    `TSRE_ASSERT_NEXT(a_emit_shows, cmd.emit, m_axis_tvalid, "loaded result not presented")
    `TSRE_ASSERT_NOW(a_walk_excl, cmd.walk_sel, !cmd.emit && !s_axis_tready, "walk overlaps")

endmodule

`default_nettype wire

@@ hdl/tsre_ctrl.sv @@
// Controller state machine that sequences one request through decision and backward walk.
`default_nettype none

module tsre_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_out_free,
    input  tsre_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output tsre_pkg::t_dp_cmd    o_cmd
);

    tsre_pkg::t_state r_state;
    tsre_pkg::t_state n_state;
    logic             need_emit;
    logic             stall;
    logic             walk_needed;

    assign need_emit   = i_status.big &&
                         (i_status.is_flush || i_status.new_user || !i_status.fits);
    assign stall       = need_emit && !i_out_free;
    assign walk_needed = !i_status.is_flush && !i_status.new_user &&
                         !i_status.fits && !i_status.big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsre_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsre_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tsre_pkg::S_DECIDE;
                end
            end
            tsre_pkg::S_DECIDE: begin
                if (!stall) begin
                    n_state = walk_needed ? tsre_pkg::S_WALK : tsre_pkg::S_IDLE;
                end
            end
            tsre_pkg::S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = tsre_pkg::S_IDLE;
                end
            end
            default: n_state = tsre_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tsre_pkg::S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.load_in = i_in_valid;
            end
            tsre_pkg::S_DECIDE: begin
                if (!stall) begin
                    o_cmd.emit = need_emit;
                    if (i_status.is_flush) begin
                        o_cmd.flush = 1'b1;
                    end else if (i_status.new_user) begin
                        o_cmd.new_user = 1'b1;
                    end else if (i_status.fits) begin
                        o_cmd.grow = 1'b1;
                    end else if (i_status.big) begin
                        o_cmd.reseed = 1'b1;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                    end
                end
            end
            tsre_pkg::S_WALK: begin
                o_cmd.walk_sel = 1'b1;
                if (i_status.walk_done) begin
                    o_cmd.walk_end = 1'b1;
                end else begin
                    o_cmd.absorb = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tsre_datapath.sv @@
// Datapath with the region box, counters, fit test and the circular buffer of recent points.
`default_nettype none

module tsre_datapath #(
    parameter int MAX_MIN_POINTS = 64
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  tsre_pkg::t_dp_cmd                      i_cmd,
    input  wire                                    i_in_cmd,
    input  wire  [31:0]                            i_in_user,
    input  wire  signed [tsre_pkg::COORD_W-1:0]    i_in_x,
    input  wire  signed [tsre_pkg::COORD_W-1:0]    i_in_y,
    input  wire  [tsre_pkg::EXTENT_W-1:0]          i_extent_limit,
    input  wire  [tsre_pkg::MINPTS_W-1:0]          i_min_points,
    output tsre_pkg::t_dp_status                   o_status,
    output tsre_pkg::t_region                      o_region
);

    localparam int IW = $clog2(MAX_MIN_POINTS);
    localparam int CW = $clog2(MAX_MIN_POINTS + 1);
    localparam int DW = 2 * tsre_pkg::COORD_W;

    logic                              r_in_cmd;
    logic [31:0]                       r_in_user;
    logic signed [tsre_pkg::COORD_W-1:0] r_in_x;
    logic signed [tsre_pkg::COORD_W-1:0] r_in_y;

    logic                              r_user_active;
    logic [31:0]                       r_active_user;
    logic signed [tsre_pkg::COORD_W-1:0] r_lo_x;
    logic signed [tsre_pkg::COORD_W-1:0] r_hi_x;
    logic signed [tsre_pkg::COORD_W-1:0] r_lo_y;
    logic signed [tsre_pkg::COORD_W-1:0] r_hi_y;
    logic [31:0]                       r_tally;
    logic [31:0]                       r_first;
    logic [31:0]                       r_last;
    logic [CW-1:0]                     r_fill;
    logic [IW-1:0]                     r_base;
    logic [CW-1:0]                     r_keep;
    logic [IW-1:0]                     r_taken;
    logic [IW-1:0]                     r_ptr;

    logic [DW-1:0]                     r_mem [MAX_MIN_POINTS];
    logic [DW-1:0]                     r_rd_data;

    logic [CW-1:0]                     thr;
    logic                              thr_over;
    logic signed [tsre_pkg::COORD_W-1:0] px;
    logic signed [tsre_pkg::COORD_W-1:0] py;
    logic signed [tsre_pkg::COORD_W:0] d_lo_x;
    logic signed [tsre_pkg::COORD_W:0] d_hi_x;
    logic signed [tsre_pkg::COORD_W:0] d_lo_y;
    logic signed [tsre_pkg::COORD_W:0] d_hi_y;
    logic signed [tsre_pkg::COORD_W:0] lim;
    logic                              fit;
    logic                              room;
    logic [IW-1:0]                     fill_slot;
    logic [IW-1:0]                     rd_addr;
    logic [IW-1:0]                     new_base;
    logic [IW-1:0]                     new_slot;
    logic [31:0]                       last_inc;
    logic [31:0]                       taken_ext;
    logic                              wr_en;
    logic [IW-1:0]                     wr_addr;

    function automatic logic [IW-1:0] f_wrap(input logic [IW:0] s);
        logic [IW:0] r;
        r = (s >= (IW+1)'(MAX_MIN_POINTS)) ? s - (IW+1)'(MAX_MIN_POINTS) : s;
        return r[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] a);
        return (a == '0) ? IW'(MAX_MIN_POINTS - 1) : a - IW'(1);
    endfunction

    assign thr_over = {25'd0, i_min_points} > 32'(MAX_MIN_POINTS);
    assign thr      = (i_min_points == '0) ? CW'(1) :
                      (thr_over ? CW'(MAX_MIN_POINTS) : CW'(i_min_points));

    assign px = i_cmd.walk_sel ? r_rd_data[tsre_pkg::COORD_W-1:0] : r_in_x;
    assign py = i_cmd.walk_sel ? r_rd_data[DW-1:tsre_pkg::COORD_W] : r_in_y;

    assign d_lo_x = {px[tsre_pkg::COORD_W-1], px} - {r_lo_x[tsre_pkg::COORD_W-1], r_lo_x};
    assign d_hi_x = {r_hi_x[tsre_pkg::COORD_W-1], r_hi_x} - {px[tsre_pkg::COORD_W-1], px};
    assign d_lo_y = {py[tsre_pkg::COORD_W-1], py} - {r_lo_y[tsre_pkg::COORD_W-1], r_lo_y};
    assign d_hi_y = {r_hi_y[tsre_pkg::COORD_W-1], r_hi_y} - {py[tsre_pkg::COORD_W-1], py};
    assign lim    = {2'b00, i_extent_limit};
    assign fit    = (d_lo_x <= lim) && (d_hi_x <= lim) && (d_lo_y <= lim) && (d_hi_y <= lim);

    assign room      = (r_fill < thr) && (r_fill < CW'(MAX_MIN_POINTS));
    assign fill_slot = f_wrap({1'b0, r_base} + (IW+1)'(r_fill));
    assign rd_addr   = i_cmd.walk_start ? f_dec(fill_slot) : f_dec(r_ptr);
    assign new_base  = f_wrap({1'b0, r_base} + (IW+1)'(r_keep));
    assign new_slot  = f_wrap({1'b0, new_base} + {1'b0, r_taken});
    assign last_inc  = (r_last == 32'hFFFF_FFFF) ? r_last : r_last + 32'd1;
    assign taken_ext = 32'(r_taken);

    assign o_status.is_flush  = r_in_cmd;
    assign o_status.new_user  = !r_user_active || (r_in_user > r_active_user);
    assign o_status.fits      = fit;
    assign o_status.big       = r_user_active && (r_tally >= 32'(thr));
    assign o_status.walk_done = (r_keep == '0) || (r_taken == IW'(MAX_MIN_POINTS - 1)) || !fit;

    assign o_region.region_user   = r_active_user;
    assign o_region.region_points = r_tally;
    assign o_region.start_index   = r_first;
    assign o_region.end_index     = r_last;
    assign o_region.box_min_x     = r_lo_x;
    assign o_region.box_max_x     = r_hi_x;
    assign o_region.box_min_y     = r_lo_y;
    assign o_region.box_max_y     = r_hi_y;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        if (i_cmd.new_user || i_cmd.reseed) begin
            wr_en = 1'b1;
        end else if (i_cmd.grow && room) begin
            wr_en   = 1'b1;
            wr_addr = fill_slot;
        end else if (i_cmd.walk_end) begin
            wr_en   = 1'b1;
            wr_addr = new_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_in_y, r_in_x};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_active <= 1'b0;
            r_fill        <= '0;
        end else begin
            if (i_cmd.flush) begin
                r_user_active <= 1'b0;
            end else if (i_cmd.new_user) begin
                r_user_active <= 1'b1;
            end
            if (i_cmd.new_user || i_cmd.reseed) begin
                r_fill <= CW'(1);
            end else if (i_cmd.grow && room) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_cmd.walk_end) begin
                r_fill <= CW'({1'b0, r_taken} + (IW+1)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_cmd  <= i_in_cmd;
            r_in_user <= i_in_user;
            r_in_x    <= i_in_x;
            r_in_y    <= i_in_y;
        end
        if (i_cmd.new_user) begin
            r_active_user <= r_in_user;
        end
        if (i_cmd.new_user || i_cmd.reseed || i_cmd.walk_start) begin
            r_lo_x <= r_in_x;
            r_hi_x <= r_in_x;
            r_lo_y <= r_in_y;
            r_hi_y <= r_in_y;
        end else if (i_cmd.grow || i_cmd.absorb) begin
            if (px < r_lo_x) r_lo_x <= px;
            if (px > r_hi_x) r_hi_x <= px;
            if (py < r_lo_y) r_lo_y <= py;
            if (py > r_hi_y) r_hi_y <= py;
        end
        if (i_cmd.new_user || i_cmd.reseed) begin
            r_tally <= 32'd1;
            r_base  <= '0;
        end else if (i_cmd.grow) begin
            r_tally <= (r_tally == 32'hFFFF_FFFF) ? r_tally : r_tally + 32'd1;
        end else if (i_cmd.walk_end) begin
            r_tally <= taken_ext + 32'd1;
            r_base  <= new_base;
        end
        if (i_cmd.new_user) begin
            r_first <= '0;
            r_last  <= '0;
        end else if (i_cmd.grow) begin
            r_last <= last_inc;
        end else if (i_cmd.reseed) begin
            r_first <= last_inc;
            r_last  <= last_inc;
        end else if (i_cmd.walk_end) begin
            r_first <= (taken_ext > last_inc) ? '0 : last_inc - taken_ext;
            r_last  <= last_inc;
        end
        if (i_cmd.walk_start) begin
            r_keep  <= r_fill;
            r_taken <= '0;
            r_ptr   <= rd_addr;
        end else if (i_cmd.absorb) begin
            r_keep  <= r_keep - CW'(1);
            r_taken <= r_taken + IW'(1);
            r_ptr   <= rd_addr;
        end
    end

endmodule

`default_nettype wire
